FILE: hw/rtl/tegd_pkg.sv
// Shared types, codes and reset values for the touch gesture detector.
// No dependencies; every other file imports this package.
package tegd_pkg;

  localparam int unsigned MOVE_MIN  = 2;
  localparam int unsigned COUNT_MAX = 3;

  // Configuration register indexes
  localparam logic [2:0] REG_TOUCH_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_GESTURE_ENABLE  = 3'd1;
  localparam logic [2:0] REG_TAP_TIMEOUT     = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS      = 3'd3;
  localparam logic [2:0] REG_SWIPE_THRESHOLD = 3'd4;

  localparam logic [11:0] RST_TOUCH_THRESHOLD = 12'd100;
  localparam logic [15:0] RST_TAP_TIMEOUT     = 16'd200;
  localparam logic [15:0] RST_LONG_PRESS      = 16'd500;
  localparam logic [9:0]  RST_SWIPE_THRESHOLD = 10'd30;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_MOVE    = 2'd2,
    EV_RELEASE = 2'd3
  } touch_event_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2,
    ST_RELEASED = 2'd3
  } touch_state_t;

  typedef enum logic [2:0] {
    G_NONE  = 3'd0,
    G_TAP   = 3'd1,
    G_LONG  = 3'd2,
    G_RIGHT = 3'd3,
    G_LEFT  = 3'd4,
    G_DOWN  = 3'd5,
    G_UP    = 3'd6
  } gesture_t;

  typedef struct packed {
    logic [11:0] touch_threshold;
    logic        gesture_enable;
    logic [15:0] tap_timeout_ms;
    logic [15:0] long_press_ms;
    logic [9:0]  swipe_threshold;
  } cfg_t;

  typedef struct packed {
    logic [11:0] pressure;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [31:0] now_ms;
  } scan_t;

  typedef struct packed {
    touch_event_t touch_event;
    touch_state_t touch_state;
    logic [9:0]   point_x;
    logic [9:0]   point_y;
    logic         gesture_valid;
    gesture_t     gesture;
  } result_t;

  // Classified scan passed from the front to the back
  typedef struct packed {
    touch_state_t kind;
    logic [9:0]   pos_x;
    logic [9:0]   pos_y;
    logic         long_hit;
    logic         tap_hit;
  } cmd_t;

endpackage

FILE: hw/rtl/tegd_if.sv
// Valid/ready channel interfaces for scan input and result output.
// Depends on tegd_pkg.
interface tegd_scan_if import tegd_pkg::*; ();
  logic  valid;
  logic  ready;
  scan_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tegd_result_if import tegd_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tegd_front.sv
// Front end: accepts scans, tracks touch/release and press time, classifies.
// Depends on tegd_pkg and tegd_if.
module tegd_front import tegd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tegd_scan_if.sink         in_scan,
  input  cfg_t              cfg,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic        touched_r, touched_nxt;
  logic [31:0] press_time_r, press_time_nxt;
  logic        now_touched;
  logic [31:0] dur;

  assign in_scan.ready = !q_full;
  assign q_push        = in_scan.valid && !q_full;

  always_comb begin
    now_touched    = in_scan.data.pressure > cfg.touch_threshold;
    dur            = in_scan.data.now_ms - press_time_r;
    touched_nxt    = touched_r;
    press_time_nxt = press_time_r;
    q_cmd.pos_x    = in_scan.data.pos_x;
    q_cmd.pos_y    = in_scan.data.pos_y;
    q_cmd.long_hit = dur > {16'd0, cfg.long_press_ms};
    q_cmd.tap_hit  = dur < {16'd0, cfg.tap_timeout_ms};
    if (now_touched && !touched_r) begin
      q_cmd.kind     = ST_PRESSED;
      touched_nxt    = 1'b1;
      press_time_nxt = in_scan.data.now_ms;
    end else if (now_touched) begin
      q_cmd.kind = ST_HELD;
    end else if (touched_r) begin
      q_cmd.kind  = ST_RELEASED;
      touched_nxt = 1'b0;
    end else begin
      q_cmd.kind = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r    <= 1'b0;
      press_time_r <= '0;
    end else if (q_push) begin
      touched_r    <= touched_nxt;
      press_time_r <= press_time_nxt;
    end
  end

endmodule

FILE: hw/rtl/tegd_queue.sv
// Two-entry queue of classified scans between front and back.
// Depends on tegd_pkg.
module tegd_queue import tegd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

endmodule

FILE: hw/rtl/tegd_back.sv
// Back end: tracks points, motion and gestures, drives the result register.
// Depends on tegd_pkg and tegd_if.
module tegd_back import tegd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          clr_count,
  input  logic          q_empty,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  tegd_result_if.source out_res
);

  logic [9:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [9:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [1:0] count_r, count_nxt;
  gesture_t   held_r, held_nxt;
  result_t    out_r, out_nxt;
  logic       out_valid_r;
  logic [9:0] dx, dy, ax, ay;
  logic       moved;

  function automatic logic [9:0] absdiff(input logic [9:0] a, input logic [9:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign q_pop         = !q_empty && (!out_valid_r || out_res.ready);
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_r;

  always_comb begin
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    last_x_nxt  = last_x_r;
    last_y_nxt  = last_y_r;
    count_nxt   = count_r;
    held_nxt    = held_r;
    dx          = absdiff(q_cmd.pos_x, last_x_r);
    dy          = absdiff(q_cmd.pos_y, last_y_r);
    moved       = dx > 10'(MOVE_MIN) || dy > 10'(MOVE_MIN);
    ax          = absdiff(last_x_r, start_x_r);
    ay          = absdiff(last_y_r, start_y_r);
    out_nxt.touch_event   = EV_NONE;
    out_nxt.touch_state   = q_cmd.kind;
    out_nxt.gesture_valid = 1'b0;
    out_nxt.gesture       = G_NONE;
    unique case (q_cmd.kind)
      ST_PRESSED: begin
        out_nxt.touch_event = EV_PRESS;
        start_x_nxt = q_cmd.pos_x;
        start_y_nxt = q_cmd.pos_y;
        last_x_nxt  = q_cmd.pos_x;
        last_y_nxt  = q_cmd.pos_y;
        if (count_r != 2'(COUNT_MAX)) count_nxt = count_r + 2'd1;
      end
      ST_HELD: begin
        if (moved) begin
          out_nxt.touch_event = EV_MOVE;
          last_x_nxt = q_cmd.pos_x;
          last_y_nxt = q_cmd.pos_y;
          if (count_r != 2'(COUNT_MAX)) count_nxt = count_r + 2'd1;
        end
        if (q_cmd.long_hit && cfg.gesture_enable) begin
          held_nxt              = G_LONG;
          out_nxt.gesture_valid = 1'b1;
          out_nxt.gesture       = G_LONG;
        end
      end
      ST_RELEASED: begin
        out_nxt.touch_event = EV_RELEASE;
        if (cfg.gesture_enable) begin
          // few recorded points keep the earlier gesture
          priority if (q_cmd.tap_hit) begin
            held_nxt = G_TAP;
          end else if (count_r == 2'(COUNT_MAX)) begin
            if (ax > cfg.swipe_threshold || ay > cfg.swipe_threshold) begin
              if (ax > ay) held_nxt = (last_x_r > start_x_r) ? G_RIGHT : G_LEFT;
              else         held_nxt = (last_y_r > start_y_r) ? G_DOWN : G_UP;
            end else begin
              held_nxt = G_TAP;
            end
          end else begin
            held_nxt = held_r;
          end
          if (held_nxt != G_NONE) begin
            out_nxt.gesture_valid = 1'b1;
            out_nxt.gesture       = held_nxt;
          end
        end
      end
      ST_IDLE: begin
      end
      default: begin
      end
    endcase
    out_nxt.point_x = last_x_nxt;
    out_nxt.point_y = last_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= '0;
      start_y_r   <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      count_r     <= '0;
      held_r      <= G_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        start_x_r <= start_x_nxt;
        start_y_r <= start_y_nxt;
        last_x_r  <= last_x_nxt;
        last_y_r  <= last_y_nxt;
        held_r    <= held_nxt;
      end
      // config writes are meant to land only while idle; the block does not enforce it; clear takes priority
      if (clr_count)  count_r <= '0;
      else if (q_pop) count_r <= count_nxt;
      if (q_pop)              out_valid_r <= 1'b1;
      else if (out_res.ready) out_valid_r <= 1'b0;
    end
  end

  a_gesture_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.gesture_valid |-> out_r.gesture == G_NONE)
    else $error("gesture code without gesture_valid");
  a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.touch_event == EV_PRESS |-> out_r.touch_state == ST_PRESSED)
    else $error("press event outside pressed state");
  a_press_counts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_cmd.kind == ST_PRESSED && !clr_count |=> count_r != 2'd0)
    else $error("press did not count a point");
  a_long_only_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.gesture == G_LONG |-> out_r.touch_state != ST_IDLE)
    else $error("long press reported while idle");

endmodule

FILE: hw/rtl/touch_event_gesture_detector.sv
// Touch event and gesture detector, top level: configuration registers,
// front classifier, two-entry queue and back end. Depends on tegd_pkg, tegd_if.
// A scan is written into a queue slot; the back pops it into the result register.
// Throughput: one scan per cycle while out_res.ready holds; otherwise the back stalls.
// Reset (rst_n, synchronous): config returns to defaults, touch state is cleared.
module touch_event_gesture_detector import tegd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  tegd_scan_if.sink     in_scan,
  tegd_result_if.source out_res,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata
);

  cfg_t cfg_r;
  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, pop_cmd;
  logic clr_count;

  assign clr_count = cfg_we && cfg_index == REG_GESTURE_ENABLE && cfg_wdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_threshold <= RST_TOUCH_THRESHOLD;
      cfg_r.gesture_enable  <= 1'b0;
      cfg_r.tap_timeout_ms  <= RST_TAP_TIMEOUT;
      cfg_r.long_press_ms   <= RST_LONG_PRESS;
      cfg_r.swipe_threshold <= RST_SWIPE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOUCH_THRESHOLD: cfg_r.touch_threshold <= cfg_wdata[11:0];
        REG_GESTURE_ENABLE:  cfg_r.gesture_enable  <= cfg_wdata[0];
        REG_TAP_TIMEOUT:     cfg_r.tap_timeout_ms  <= cfg_wdata;
        REG_LONG_PRESS:      cfg_r.long_press_ms   <= cfg_wdata;
        REG_SWIPE_THRESHOLD: cfg_r.swipe_threshold <= cfg_wdata[9:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  tegd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_scan(in_scan),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  tegd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .pop_cmd (pop_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  tegd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .clr_count(clr_count),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .out_res  (out_res)
  );

endmodule
